// ===== rtl/core/block_cipher_256_encrypt_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the block cipher core.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CIPHER_256_ENCRYPT_TOP_MACROS_SVH
`define BLOCK_CIPHER_256_ENCRYPT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BC_ASSERT_SAME(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) \
		(ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BC_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bc256_pkg.sv =====
// ----------------------------------------------------------------------------
// Block cipher package
// Types, register codes and round functions of the 256-bit block cipher.
// ----------------------------------------------------------------------------
package bc256_pkg;

	localparam int WORD_W    = 64;
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3 = 2'd3;

	typedef struct packed {
		word_t plain_a;
		word_t plain_b;
		word_t plain_c;
		word_t plain_d;
	} plain_t;

	typedef struct packed {
		word_t cipher_a;
		word_t cipher_b;
		word_t cipher_c;
		word_t cipher_d;
	} cipher_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} blk_t;

	typedef struct packed {
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
	} key_t;

	function automatic word_t rol(input word_t x, input int unsigned n);
		int unsigned m;
		m = n % WORD_W;
		if (m == 0) begin
			return x;
		end
		return (x << m) | (x >> (WORD_W - m));
	endfunction

	function automatic word_t round_const(input word_t r);
		word_t x;
		x = r;
		x = x ^ rol(x, 3);
		x = x ^ rol(x, 6);
		x = x ^ rol(x, 17);
		x = x ^ rol(x, 15);
		x = x ^ rol(x, 24);
		return x;
	endfunction

	function automatic blk_t mix_layer(input blk_t s, input int unsigned r0,
			input int unsigned r1, input int unsigned r2);
		blk_t w;
		w   = s;
		w.b = rol(w.b, r0);
		w.c = rol(w.c, r1);
		w.d = rol(w.d, r2);
		w.a = w.a ^ w.d;
		w.b = w.b ^ w.c;
		w.c = w.c ^ w.a;
		w.d = w.d ^ w.b;
		return w;
	endfunction

	function automatic blk_t nonlinear(input blk_t s);
		blk_t  w;
		word_t t;
		w   = s;
		t   = w.a;
		w.a = (w.a & w.b) ^ w.c;
		w.c = (w.b & w.c) ^ w.d;
		w.d = (w.d & w.a) ^ t;
		w.b = w.b ^ (w.c & t);
		return w;
	endfunction

	function automatic blk_t round_fn(input blk_t s, input word_t rc);
		blk_t w;
		w   = s;
		w.a = w.a ^ rc;
		w   = mix_layer(w, 1, 2, 3);
		w   = mix_layer(w, 4, 8, 12);
		w   = mix_layer(w, 16, 32, 48);
		w   = nonlinear(w);
		return w;
	endfunction

endpackage

// ===== rtl/core/bc256_round_cell.sv =====
// ----------------------------------------------------------------------------
// Round cell
// One cipher round with its own fixed constant, registered at the output.
// ----------------------------------------------------------------------------
module bc256_round_cell #(
	parameter int ROUND_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  bc256_pkg::blk_t  blk_in,
	output logic             vld_out,
	output bc256_pkg::blk_t  blk_out
);

	localparam bc256_pkg::word_t RC =
		bc256_pkg::round_const(bc256_pkg::word_t'(ROUND_IDX));

	logic            vld_s1;
	bc256_pkg::blk_t blk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		blk_s1 <= bc256_pkg::round_fn(blk_in, RC);
	end

	assign vld_out = vld_s1;
	assign blk_out = blk_s1;

endmodule

// ===== rtl/core/block_cipher_256_encrypt_top.sv =====
// ----------------------------------------------------------------------------
// 256-bit block cipher, encryption
// Key whitening, a chain of round cells and a final key whitening stage.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake                  Payload
// input      in         start (busy is never high)  plain
// result     out        done, one-cycle strobe      cipher
// config     in         cfg_we                      cfg_index, cfg_wdata
//
// An item is taken in every cycle in which start is high.
// Its result passes through one whitening stage, one round cell per round
// and one output stage, each a register.
// Reset clears the key registers and all valid flags of the chain.
// The receiver cannot stall, so nothing ever holds the chain back.
// ----------------------------------------------------------------------------
`include "block_cipher_256_encrypt_top_macros.svh"

module block_cipher_256_encrypt_top #(
	parameter int LAST_ROUND = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  bc256_pkg::plain_t                   plain,
	output logic                                done,
	output bc256_pkg::cipher_t                  cipher,
	input  logic                                cfg_we,
	input  logic [bc256_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  bc256_pkg::word_t                    cfg_wdata
);

	localparam int NUM_CELLS = LAST_ROUND + 1;

	bc256_pkg::key_t key_q;
	logic            front_vld_s1;
	bc256_pkg::blk_t front_blk_s1;
	logic            back_vld_s2;
	bc256_pkg::blk_t back_blk_s2;
	logic            take;

	logic            [NUM_CELLS:0] cell_vld;
	bc256_pkg::blk_t [NUM_CELLS:0] cell_blk;

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bc256_pkg::REG_KEY_0: key_q.k0 <= cfg_wdata;
				bc256_pkg::REG_KEY_1: key_q.k1 <= cfg_wdata;
				bc256_pkg::REG_KEY_2: key_q.k2 <= cfg_wdata;
				bc256_pkg::REG_KEY_3: key_q.k3 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_s1 <= 1'b0;
			back_vld_s2  <= 1'b0;
		end else begin
			front_vld_s1 <= take;
			back_vld_s2  <= cell_vld[NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		front_blk_s1.a <= plain.plain_a ^ key_q.k0;
		front_blk_s1.b <= plain.plain_b ^ key_q.k1;
		front_blk_s1.c <= plain.plain_c ^ key_q.k2;
		front_blk_s1.d <= plain.plain_d ^ key_q.k3;
		back_blk_s2.a  <= cell_blk[NUM_CELLS].a ^ key_q.k0;
		back_blk_s2.b  <= cell_blk[NUM_CELLS].b ^ key_q.k1;
		back_blk_s2.c  <= cell_blk[NUM_CELLS].c ^ key_q.k2;
		back_blk_s2.d  <= cell_blk[NUM_CELLS].d ^ key_q.k3;
	end

	assign cell_vld[0] = front_vld_s1;
	assign cell_blk[0] = front_blk_s1;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_round
		bc256_round_cell #(
			.ROUND_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (cell_vld[i]),
			.blk_in  (cell_blk[i]),
			.vld_out (cell_vld[i+1]),
			.blk_out (cell_blk[i+1])
		);
	end

	assign done            = back_vld_s2;
	assign cipher.cipher_a = back_blk_s2.a;
	assign cipher.cipher_b = back_blk_s2.b;
	assign cipher.cipher_c = back_blk_s2.c;
	assign cipher.cipher_d = back_blk_s2.d;

	`BC_ASSERT_NEXT(a_take_enters_chain, clk, arst_n, take, front_vld_s1, "accepted item lost at entry")
	`BC_ASSERT_SAME(a_done_from_chain, clk, arst_n, done, $past(cell_vld[NUM_CELLS]), "result without item in last cell")
	`BC_ASSERT_NEXT(a_key_held, clk, arst_n, !cfg_we, $stable(key_q), "key changed without a write")

endmodule

// ===== dv/block_cipher_256_encrypt_checker.sv =====
// ----------------------------------------------------------------------------
// Block cipher checker
// Watches the item, result and key write channels of the encryption core.
// It keeps its own copy of the key words and works out the ciphertext of
// every accepted item. Each result strobe is then compared word by word
// against the oldest ciphertext still due.
// ----------------------------------------------------------------------------
module block_cipher_256_encrypt_checker #(
	parameter int LAST_ROUND = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  bc256_pkg::plain_t               plain,
	input  logic                            done,
	input  bc256_pkg::cipher_t              cipher,
	input  logic                            cfg_we,
	input  logic [bc256_pkg::CFG_IDX_W-1:0] cfg_index,
	input  bc256_pkg::word_t                cfg_wdata,
	output int                              errors,
	output int                              pending
);

	import bc256_pkg::*;

	word_t   key_q [4];
	cipher_t cipher_due_q [$];
	cipher_t due;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_failure(input string msg);
		$display("ERROR: %s", msg);
		errors = errors + 1;
	endtask

	task automatic check_word(input string field, input word_t got, input word_t want);
		if (got !== want) begin
			report_failure($sformatf("%s is %h, expected %h", field, got, want));
		end
	endtask

	function automatic word_t rotl(input word_t x, input int unsigned n);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} << n;
		return dbl[2*WORD_W-1:WORD_W];
	endfunction

	function automatic cipher_t encipher(input plain_t p);
		word_t   w [4];
		word_t   rc;
		word_t   t;
		cipher_t c;
		w[0] = p.plain_a ^ key_q[REG_KEY_0];
		w[1] = p.plain_b ^ key_q[REG_KEY_1];
		w[2] = p.plain_c ^ key_q[REG_KEY_2];
		w[3] = p.plain_d ^ key_q[REG_KEY_3];
		for (int r = 0; r <= LAST_ROUND; r++) begin
			rc = word_t'(r);
			rc = rc ^ rotl(rc, 3);
			rc = rc ^ rotl(rc, 6);
			rc = rc ^ rotl(rc, 17);
			rc = rc ^ rotl(rc, 15);
			rc = rc ^ rotl(rc, 24);
			w[0] = w[0] ^ rc;
			// The three layers rotate word j by j, 4j and 16j.
			for (int layer = 0; layer < 3; layer++) begin
				for (int j = 1; j < 4; j++) begin
					w[j] = rotl(w[j], j << (2 * layer));
				end
				w[0] = w[0] ^ w[3];
				w[1] = w[1] ^ w[2];
				w[2] = w[2] ^ w[0];
				w[3] = w[3] ^ w[1];
			end
			t    = w[0];
			w[0] = (w[0] & w[1]) ^ w[2];
			w[2] = (w[1] & w[2]) ^ w[3];
			w[3] = (w[3] & w[0]) ^ t;
			w[1] = w[1] ^ (w[2] & t);
		end
		c.cipher_a = w[0] ^ key_q[REG_KEY_0];
		c.cipher_b = w[1] ^ key_q[REG_KEY_1];
		c.cipher_c = w[2] ^ key_q[REG_KEY_2];
		c.cipher_d = w[3] ^ key_q[REG_KEY_3];
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_due_q.delete();
			foreach (key_q[i]) begin
				key_q[i] = '0;
			end
		end else begin
			if (cfg_we) begin
				key_q[cfg_index] = cfg_wdata;
			end
			if (done) begin
				if (cipher_due_q.size() == 0) begin
					report_failure("result strobe with no item outstanding");
				end else begin
					due = cipher_due_q.pop_front();
					check_word("cipher_a", cipher.cipher_a, due.cipher_a);
					check_word("cipher_b", cipher.cipher_b, due.cipher_b);
					check_word("cipher_c", cipher.cipher_c, due.cipher_c);
					check_word("cipher_d", cipher.cipher_d, due.cipher_d);
				end
			end
			if (start && !busy) begin
				cipher_due_q.push_back(encipher(plain));
			end
		end
		pending = cipher_due_q.size();
	end

endmodule

// ===== dv/block_cipher_256_encrypt_top_tb.sv =====
// ----------------------------------------------------------------------------
// Block cipher testbench
// Drives plaintext items into the encryption core under a series of keys,
// all-zero, all-one, patterned and random, with random gaps between items.
// A short directed set covers the extreme words before the random items.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module block_cipher_256_encrypt_top_tb;

	import bc256_pkg::*;

	localparam int LAST_ROUND   = 16;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 200;
	localparam int STALL_LIMIT  = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	plain_t               plain;
	logic                 done;
	cipher_t              cipher;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	word_t                cfg_wdata;
	int                   errors;
	int                   pending;
	int                   stall_cycles;

	block_cipher_256_encrypt_top #(
		.LAST_ROUND(LAST_ROUND)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.plain    (plain),
		.done     (done),
		.cipher   (cipher),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	block_cipher_256_encrypt_checker #(
		.LAST_ROUND(LAST_ROUND)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.plain    (plain),
		.done     (done),
		.cipher   (cipher),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	function automatic word_t rand_word();
		word_t one_hot;
		word_t w;
		one_hot = word_t'(1) << $urandom_range(0, WORD_W - 1);
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = one_hot;
			3: w = ~one_hot;
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	task automatic send_block(input plain_t p, input int gap);
		logic stalled;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		plain <= p;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LAST_ROUND + 8) @(posedge clk);
	endtask

	task automatic program_key(input word_t k0, input word_t k1, input word_t k2,
			input word_t k3);
		logic [CFG_IDX_W-1:0] idx [4];
		word_t                val [4];
		idx[0] = REG_KEY_0;
		idx[1] = REG_KEY_1;
		idx[2] = REG_KEY_2;
		idx[3] = REG_KEY_3;
		val[0] = k0;
		val[1] = k1;
		val[2] = k2;
		val[3] = k3;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		plain_t directed [$];
		word_t  alt_a;
		word_t  alt_5;
		word_t  msb;
		bit     no_gaps;
		int     gap;

		arst_n       = 1'b0;
		start        = 1'b0;
		plain        = '0;
		cfg_we       = 1'b0;
		cfg_index    = REG_KEY_0;
		cfg_wdata    = '0;
		stall_cycles = 0;
		no_gaps      = 1'b0;
		alt_a        = {32{2'b10}};
		alt_5        = {32{2'b01}};
		msb          = word_t'(1) << (WORD_W - 1);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(plain_t'{'0, '0, '0, '0});
		directed.push_back(plain_t'{'1, '1, '1, '1});
		directed.push_back(plain_t'{'1, '0, '0, '0});
		directed.push_back(plain_t'{'0, '1, '0, '0});
		directed.push_back(plain_t'{'0, '0, '1, '0});
		directed.push_back(plain_t'{'0, '0, '0, '1});
		directed.push_back(plain_t'{alt_a, alt_5, alt_a, alt_5});
		directed.push_back(plain_t'{alt_5, alt_a, alt_5, alt_a});
		directed.push_back(plain_t'{msb, msb, msb, msb});
		directed.push_back(plain_t'{word_t'(1), word_t'(1), word_t'(1), word_t'(1)});
		directed.push_back(plain_t'{~msb, '1, '0, word_t'(1)});
		foreach (directed[i]) begin
			send_block(directed[i], $urandom_range(0, 14));
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				wait_idle();
				case (phase)
					1: program_key('1, '1, '1, '1);
					2: program_key('0, '1, alt_a, alt_5);
					3: program_key('0, '0, '0, '0);
					default: program_key(rand_word(), rand_word(), rand_word(), rand_word());
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0) begin
					no_gaps = ($urandom_range(0, 2) == 0);
				end
				gap = no_gaps ? 0 : $urandom_range(0, 14);
				send_block(plain_t'{rand_word(), rand_word(), rand_word(), rand_word()}, gap);
			end
		end

		wait_idle();
		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bc256_pkg.sv
rtl/core/bc256_round_cell.sv
rtl/core/block_cipher_256_encrypt_top.sv
dv/block_cipher_256_encrypt_checker.sv
dv/block_cipher_256_encrypt_top_tb.sv
